@@ rtl/sccb_register_access_master_top_defines.svh @@
// assertion macros for the sccb register access master
// used by the top level only, no other dependencies
`ifndef SCCB_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define SCCB_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SCCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sccb assertion failed");
`define SCCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sccb assertion failed");
`else
`define SCCB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/sccb_pkg.sv @@
// shared types and constants of the sccb register access master
// no dependencies
`default_nettype none

package sccb_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_HALF_BIT = 2'd1;
  localparam logic [1:0] REG_SETUP    = 2'd2;
  localparam logic [1:0] REG_GAP      = 2'd3;

  localparam logic [7:0] RST_DEV_ADDR = 8'h78;
  localparam logic [7:0] RST_HALF_BIT = 8'd80;
  localparam logic [7:0] RST_SETUP    = 8'd20;
  localparam logic [7:0] RST_GAP      = 8'd100;

  localparam logic [2:0] BYTE_DEV     = 3'd0;
  localparam logic [2:0] BYTE_ADDR_HI = 3'd1;
  localparam logic [2:0] BYTE_ADDR_LO = 3'd2;
  localparam logic [2:0] BYTE_DATA    = 3'd3;
  localparam logic [2:0] BYTE_RD_DEV  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [17:0] {
    PH_IDLE     = 18'h00001,
    PH_START_A  = 18'h00002,
    PH_START_B  = 18'h00004,
    PH_WSETUP   = 18'h00008,
    PH_WHIGH    = 18'h00010,
    PH_WLOW     = 18'h00020,
    PH_ACK_REL  = 18'h00040,
    PH_ACK_HIGH = 18'h00080,
    PH_STOP_A   = 18'h00100,
    PH_STOP_B   = 18'h00200,
    PH_STOP_C   = 18'h00400,
    PH_GAP      = 18'h00800,
    PH_RLOW     = 18'h01000,
    PH_RHIGH    = 18'h02000,
    PH_NA_A     = 18'h04000,
    PH_NA_B     = 18'h08000,
    PH_NA_C     = 18'h10000,
    PH_NA_D     = 18'h20000
  } phase_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] half_bit;
    logic [7:0] setup;
    logic [7:0] gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] register_address;
    logic [7:0]  write_value;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_drive;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       request_ignored;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/sccb_req_if.sv @@
// request channel of the sccb master: one bus tick per transfer
// no dependencies
`default_nettype none

interface sccb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] register_address;
  logic [7:0]  write_value;
  logic        sda_in;

  modport source (output valid, operation, register_address, write_value, sda_in,
                  input ready);
  modport sink (input valid, operation, register_address, write_value, sda_in,
                output ready);
endinterface

`default_nettype wire

@@ rtl/sccb_rsp_if.sv @@
// result channel of the sccb master: line levels and status per tick
// no dependencies
`default_nettype none

interface sccb_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_drive;
  logic       sda_drive_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       request_ignored;

  modport source (output valid, scl_out, sda_drive, sda_drive_enable, busy_res,
                  done_res, read_value, request_ignored,
                  input ready);
  modport sink (input valid, scl_out, sda_drive, sda_drive_enable, busy_res,
                done_res, read_value, request_ignored,
                output ready);
endinterface

`default_nettype wire

@@ rtl/sccb_cfg.sv @@
// apb-style configuration registers of the sccb master
// depends on sccb_pkg
`default_nettype none

module sccb_cfg import sccb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr <= RST_DEV_ADDR;
      cfg_r.half_bit <= RST_HALF_BIT;
      cfg_r.setup    <= RST_SETUP;
      cfg_r.gap      <= RST_GAP;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEV_ADDR: cfg_r.dev_addr <= pwdata[7:0];
        REG_HALF_BIT: cfg_r.half_bit <= pwdata[7:0];
        REG_SETUP:    cfg_r.setup    <= pwdata[7:0];
        REG_GAP:      cfg_r.gap      <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEV_ADDR: rd_byte = cfg_r.dev_addr;
      REG_HALF_BIT: rd_byte = cfg_r.half_bit;
      REG_SETUP:    rd_byte = cfg_r.setup;
      REG_GAP:      rd_byte = cfg_r.gap;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_byte};
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

@@ rtl/sccb_core.sv @@
// bit-level sequencer of the sccb master, advanced by one tick per transfer
// depends on sccb_pkg
`default_nettype none

module sccb_core import sccb_pkg::*; #(
  parameter int DELAY_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output rsp_t      rsp
);

  localparam int WB = (DELAY_BITS > 8) ? DELAY_BITS : 8;
  localparam logic [WB-1:0] WMAX = WB'({DELAY_BITS{1'b1}});

  phase_t                phase_r, phase_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [2:0]            byte_idx_r, byte_idx_nxt;
  logic [DELAY_BITS-1:0] wait_r, wait_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [15:0]           addr_r, addr_nxt;
  logic [7:0]            value_r, value_nxt;
  logic                  is_read_r, is_read_nxt;
  logic [7:0]            result_r, result_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  sda_en_r, sda_en_nxt;
  logic                  start_req, do_adv, begin_b, ignored, done;
  logic [7:0]            tx_byte;

  function automatic logic [DELAY_BITS-1:0] hold_load(input logic [7:0] ticks);
    logic [7:0]    t;
    logic [WB-1:0] te;
    t  = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
    te = WB'(t);
    if (te > WMAX) te = WMAX;
    return te[DELAY_BITS-1:0];
  endfunction

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_idx_nxt = byte_idx_r;
    wait_nxt     = wait_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    value_nxt    = value_r;
    is_read_nxt  = is_read_r;
    result_nxt   = result_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    sda_en_nxt   = sda_en_r;
    do_adv       = 1'b0;
    begin_b      = 1'b0;
    ignored      = 1'b0;
    done         = 1'b0;
    tx_byte      = 8'd0;
    start_req    = (req.operation == OP_WRITE) || (req.operation == OP_READ);

    if (start_req && phase_r == PH_IDLE) begin
      addr_nxt     = req.register_address;
      value_nxt    = req.write_value;
      is_read_nxt  = (req.operation == OP_READ);
      byte_idx_nxt = BYTE_DEV;
      bit_cnt_nxt  = 4'd0;
      do_adv       = 1'b1;
    end else begin
      ignored = start_req;
      if (phase_r != PH_IDLE) begin
        if (wait_r != '0) wait_nxt = wait_r - 1'b1;
        else do_adv = 1'b1;
      end
    end

    if (do_adv) begin
      unique case (phase_r)
        PH_IDLE, PH_GAP: begin
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
          sda_en_nxt = 1'b1;
          phase_nxt  = PH_START_A;
          wait_nxt   = hold_load(cfg.half_bit);
        end
        PH_START_A: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START_B;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_START_B: begin_b = 1'b1;
        PH_WSETUP: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WHIGH;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_WHIGH: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          phase_nxt   = PH_WLOW;
          wait_nxt    = hold_load(cfg.half_bit);
        end
        PH_WLOW: begin
          if (bit_cnt_r < BITS_PER_BYTE) begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_WSETUP;
            wait_nxt  = hold_load(cfg.setup);
          end else begin
            sda_en_nxt = 1'b0;
            phase_nxt  = PH_ACK_REL;
            wait_nxt   = hold_load(cfg.half_bit);
          end
        end
        PH_ACK_REL: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_ACK_HIGH;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_ACK_HIGH: begin
          scl_nxt = 1'b0;
          priority if (byte_idx_r >= BYTE_RD_DEV) begin
            sda_en_nxt  = 1'b0;
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            phase_nxt   = PH_RLOW;
            wait_nxt    = hold_load(cfg.half_bit);
          end else if (byte_idx_r == (is_read_r ? BYTE_ADDR_LO : BYTE_DATA)) begin
            sda_en_nxt = 1'b1;
            sda_nxt    = 1'b0;
            phase_nxt  = PH_STOP_A;
            wait_nxt   = hold_load(cfg.half_bit);
          end else begin
            byte_idx_nxt = byte_idx_r + 3'd1;
            begin_b      = 1'b1;
          end
        end
        PH_STOP_A: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_STOP_B;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_STOP_B: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_STOP_C;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_STOP_C: begin
          byte_idx_nxt = BYTE_RD_DEV;
          phase_nxt    = PH_GAP;
          wait_nxt     = hold_load(cfg.gap);
        end
        PH_RLOW: begin
          scl_nxt     = 1'b1;
          shift_nxt   = {shift_r[6:0], req.sda_in};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          phase_nxt   = PH_RHIGH;
          wait_nxt    = hold_load(cfg.half_bit);
        end
        PH_RHIGH: begin
          scl_nxt = 1'b0;
          if (bit_cnt_r < BITS_PER_BYTE) begin
            phase_nxt = PH_RLOW;
          end else begin
            result_nxt = shift_r;
            sda_en_nxt = 1'b1;
            phase_nxt  = PH_NA_A;
          end
          wait_nxt = hold_load(cfg.half_bit);
        end
        PH_NA_A: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = PH_NA_B;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_NA_B: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_NA_C;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_NA_C: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_NA_D;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        PH_NA_D: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_STOP_A;
          wait_nxt  = hold_load(cfg.half_bit);
        end
        default: begin
          phase_nxt  = PH_IDLE;
          wait_nxt   = '0;
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
          sda_en_nxt = 1'b1;
        end
      endcase
    end

    if (begin_b) begin
      unique case (byte_idx_nxt)
        BYTE_DEV:     tx_byte = cfg.dev_addr;
        BYTE_ADDR_HI: tx_byte = addr_nxt[15:8];
        BYTE_ADDR_LO: tx_byte = addr_nxt[7:0];
        BYTE_DATA:    tx_byte = value_nxt;
        default:      tx_byte = cfg.dev_addr | 8'h01;
      endcase
      bit_cnt_nxt = 4'd0;
      scl_nxt     = 1'b0;
      sda_en_nxt  = 1'b1;
      sda_nxt     = tx_byte[7];
      shift_nxt   = {tx_byte[6:0], 1'b0};
      phase_nxt   = PH_WSETUP;
      wait_nxt    = hold_load(cfg.setup);
    end

    rsp.busy_res = (phase_nxt != PH_IDLE);
    if (phase_nxt == PH_STOP_C && wait_nxt == '0 &&
        !(is_read_nxt && byte_idx_nxt == BYTE_ADDR_LO)) begin
      done      = 1'b1;
      phase_nxt = PH_IDLE;
    end

    rsp.scl_out          = scl_nxt;
    rsp.sda_drive        = sda_nxt;
    rsp.sda_drive_enable = sda_en_nxt;
    rsp.done_res         = done;
    rsp.read_value       = result_nxt;
    rsp.request_ignored  = ignored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      byte_idx_r <= '0;
      wait_r     <= '0;
      shift_r    <= '0;
      addr_r     <= '0;
      value_r    <= '0;
      is_read_r  <= 1'b0;
      result_r   <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      sda_en_r   <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_idx_r <= byte_idx_nxt;
      wait_r     <= wait_nxt;
      shift_r    <= shift_nxt;
      addr_r     <= addr_nxt;
      value_r    <= value_nxt;
      is_read_r  <= is_read_nxt;
      result_r   <= result_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      sda_en_r   <= sda_en_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sccb_out.sv @@
// result register of the sccb master, drives the result channel
// depends on sccb_pkg and sccb_rsp_if
`default_nettype none

module sccb_out import sccb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire rsp_t    rsp,
  output logic         can_load,
  sccb_rsp_if.source   out_chan
);

  logic valid_r;
  rsp_t data_r;

  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= rsp;
    end
  end

  assign out_chan.valid            = valid_r;
  assign out_chan.scl_out          = data_r.scl_out;
  assign out_chan.sda_drive        = data_r.sda_drive;
  assign out_chan.sda_drive_enable = data_r.sda_drive_enable;
  assign out_chan.busy_res         = data_r.busy_res;
  assign out_chan.done_res         = data_r.done_res;
  assign out_chan.read_value       = data_r.read_value;
  assign out_chan.request_ignored  = data_r.request_ignored;

endmodule

`default_nettype wire

@@ rtl/sccb_register_access_master_top.sv @@
// sccb register access master, 16-bit register addresses
// uses sccb_pkg, sccb_req_if, sccb_rsp_if, sccb_cfg, sccb_core, sccb_out
// and the assertion macros of sccb_register_access_master_top_defines.svh
//
// usage: every transfer on in_chan is one bus timing tick. operation selects a
// plain tick, a register write or a register read; sda_in is the sampled SDA
// level of that tick. every accepted tick produces exactly one transfer on
// out_chan with the SCL/SDA levels to drive, busy/done status, the latest
// read byte and a flag for requests dropped while busy.
// a tick's result is registered and appears in the cycle after its acceptance.
// throughput: one tick per cycle; the next sequencer state is combinational and
// the result register takes a new tick in the cycle its previous result leaves.
// when out_chan stalls with a result held, in_chan.ready drops and the
// sequencer holds until the result is taken. reset (synchronous, rst_n low)
// idles the sequencer with SCL and SDA driven high and loads the default device
// address and timing registers. configuration registers sit on the apb-style
// port at byte addresses 0, 4, 8 and 12 and apply from the next step; the user
// must write them with no tick in flight, which the block does not enforce.
`default_nettype none
`include "sccb_register_access_master_top_defines.svh"

module sccb_register_access_master_top import sccb_pkg::*; #(
  parameter int DELAY_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sccb_req_if.sink                   in_chan,
  sccb_rsp_if.source                 out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;
  req_t req;
  rsp_t rsp;
  logic can_load;
  logic in_fire;

  assign in_chan.ready        = can_load;
  assign in_fire              = in_chan.valid && can_load;
  assign req.operation        = in_chan.operation;
  assign req.register_address = in_chan.register_address;
  assign req.write_value      = in_chan.write_value;
  assign req.sda_in           = in_chan.sda_in;

  sccb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sccb_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_fire),
    .req   (req),
    .cfg   (cfg),
    .rsp   (rsp)
  );

  sccb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .rsp      (rsp),
    .can_load (can_load),
    .out_chan (out_chan)
  );

  `SCCB_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_chan.valid, in_chan.ready)
  `SCCB_ASSERT_NEXT(a_result_follows_tick, clk, rst_n, in_fire, out_chan.valid)
  `SCCB_ASSERT_IMPL(a_done_is_busy, clk, rst_n, out_chan.valid && out_chan.done_res, out_chan.busy_res)
  `SCCB_ASSERT_IMPL(a_ignored_is_busy, clk, rst_n, out_chan.valid && out_chan.request_ignored, out_chan.busy_res)

endmodule

`default_nettype wire
